// ----- rtl/ngram_fingerprint_table_defines.svh -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table assertion macros
// Shared assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef NGRAM_FINGERPRINT_TABLE_DEFINES_SVH
`define NGRAM_FINGERPRINT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check a condition on every clock outside reset
`define NFT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("nft assertion failed");

// check a condition in the cycle after a trigger
`define NFT_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("nft assertion failed");

`else

`define NFT_ASSERT(lbl, cond)
`define NFT_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ----- rtl/nft_pkg.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table package
// Field widths, hash constant, operation codes and control types.
// ----------------------------------------------------------------------------
package nft_pkg;

  localparam int MODE_W  = 2;
  localparam int TOKEN_W = 31;
  localparam int FP_W    = 32;
  localparam int HASH_W  = 64;
  localparam int LEN_W   = 5;
  localparam int COUNT_W = 17;
  localparam int STAT_W  = 32;

  localparam int TABLE_ENTRIES_DEF = 4096;

  // multiplier of the running hash, split into 32-bit halves
  localparam logic [HASH_W-1:0] HASH_MUL = 64'h5851_F42D_4C95_7F2D;
  localparam logic [FP_W-1:0]   MUL_LO   = HASH_MUL[31:0];
  localparam logic [FP_W-1:0]   MUL_HI   = HASH_MUL[63:32];

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;
  localparam logic [LEN_W-1:0] LEN_MIN   = 5'd1;
  localparam logic [LEN_W-1:0] LEN_MAX   = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } nft_mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_READ,
    ST_UPDATE,
    ST_CLEAR,
    ST_RESULT
  } nft_state_t;

  // one table entry
  typedef struct packed {
    logic               valid;
    logic [FP_W-1:0]    fp;
    logic [TOKEN_W-1:0] token;
  } nft_slot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic add;
    logic div1;
    logic div2;
    logic div3;
    logic update;
    logic clr_step;
    logic load_out;
  } nft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      key_done;
    nft_mode_t mode;
    logic      sweep_last;
    logic      out_free;
  } nft_sts_t;

endpackage

// ----- rtl/nft_if.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table channels
// Request channel (key tokens) and response channel (operation results).
// ----------------------------------------------------------------------------
interface nft_req_if;
  logic                        valid;
  logic                        ready;
  logic [nft_pkg::MODE_W-1:0]  mode;
  logic [nft_pkg::TOKEN_W-1:0] token;
  logic [nft_pkg::TOKEN_W-1:0] follow_token;

  modport source (output valid, output mode, output token, output follow_token,
                  input ready);
  modport sink   (input valid, input mode, input token, input follow_token,
                  output ready);
endinterface

interface nft_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic                        fingerprint_miss;
  logic                        overwrote;
  logic [nft_pkg::TOKEN_W-1:0] token_out;
  logic [nft_pkg::COUNT_W-1:0] used_count;
  logic [nft_pkg::STAT_W-1:0]  insert_total;
  logic [nft_pkg::STAT_W-1:0]  overwrite_total;
  logic [nft_pkg::STAT_W-1:0]  lookup_total;
  logic [nft_pkg::STAT_W-1:0]  hit_total;
  logic [nft_pkg::STAT_W-1:0]  fp_miss_total;

  modport source (output valid, output found, output fingerprint_miss,
                  output overwrote, output token_out, output used_count,
                  output insert_total, output overwrite_total,
                  output lookup_total, output hit_total, output fp_miss_total,
                  input ready);
  modport sink   (input valid, input found, input fingerprint_miss,
                  input overwrite_total, input overwrote, input token_out,
                  input used_count, input insert_total, input lookup_total,
                  input hit_total, input fp_miss_total, output ready);
endinterface

// ----- rtl/nft_ctrl.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table controller
// Sequences hashing, slot reduction, table access, clearing and results.
// ----------------------------------------------------------------------------
module nft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  nft_pkg::nft_sts_t sts,
  output nft_pkg::nft_cmd_t cmd
);

  nft_pkg::nft_state_t state;
  nft_pkg::nft_state_t state_next;

  // state register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nft_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nft_pkg::ST_INIT: begin
        if (sts.sweep_last) state_next = nft_pkg::ST_IDLE;
      end
      nft_pkg::ST_IDLE: begin
        if (req_valid) state_next = nft_pkg::ST_MUL;
      end
      nft_pkg::ST_MUL: begin
        state_next = nft_pkg::ST_ADD;
      end
      nft_pkg::ST_ADD: begin
        if (!sts.key_done) begin
          state_next = req_valid ? nft_pkg::ST_MUL : nft_pkg::ST_IDLE;
        end else begin
          case (sts.mode) inside
            nft_pkg::MODE_ADD, nft_pkg::MODE_LOOKUP: state_next = nft_pkg::ST_DIV1;
            nft_pkg::MODE_CLEAR:                     state_next = nft_pkg::ST_CLEAR;
            default:                                 state_next = nft_pkg::ST_RESULT;
          endcase
        end
      end
      nft_pkg::ST_DIV1:   state_next = nft_pkg::ST_DIV2;
      nft_pkg::ST_DIV2:   state_next = nft_pkg::ST_DIV3;
      nft_pkg::ST_DIV3:   state_next = nft_pkg::ST_READ;
      nft_pkg::ST_READ:   state_next = nft_pkg::ST_UPDATE;
      nft_pkg::ST_UPDATE: state_next = nft_pkg::ST_RESULT;
      nft_pkg::ST_CLEAR: begin
        if (sts.sweep_last) state_next = nft_pkg::ST_RESULT;
      end
      nft_pkg::ST_RESULT: begin
        if (sts.out_free) state_next = nft_pkg::ST_IDLE;
      end
      default: state_next = nft_pkg::ST_IDLE;
    endcase
  end

  // commands and request ready
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      nft_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
      end
      nft_pkg::ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      nft_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      nft_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        // take the next key token while this one is folded in
        if (!sts.key_done) begin
          req_ready   = 1'b1;
          cmd.capture = req_valid;
        end
      end
      nft_pkg::ST_DIV1:   cmd.div1 = 1'b1;
      nft_pkg::ST_DIV2:   cmd.div2 = 1'b1;
      nft_pkg::ST_DIV3:   cmd.div3 = 1'b1;
      nft_pkg::ST_READ:   cmd      = '0;
      nft_pkg::ST_UPDATE: cmd.update = 1'b1;
      nft_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      nft_pkg::ST_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/nft_datapath.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table datapath
// Running hash, slot reduction, slot memory, statistics and result register.
// ----------------------------------------------------------------------------
`include "ngram_fingerprint_table_defines.svh"

module nft_datapath #(
  parameter int TABLE_ENTRIES = nft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [nft_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic [nft_pkg::MODE_W-1:0]  req_mode,
  input  logic [nft_pkg::TOKEN_W-1:0] req_token,
  input  logic [nft_pkg::TOKEN_W-1:0] req_follow_token,
  input  nft_pkg::nft_cmd_t           cmd,
  output nft_pkg::nft_sts_t           sts,
  nft_rsp_if.source                   rsp
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int REM_W  = SLOT_W + 1;
  // reciprocal of the table size scaled by 2^32; the estimate is low by at most one
  localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / 64'(TABLE_ENTRIES);
  localparam logic [nft_pkg::FP_W-1:0] RECIP =
    (TABLE_ENTRIES == 1) ? 32'hFFFF_FFFF : RECIP_WIDE[31:0];
  localparam logic [nft_pkg::FP_W-1:0]    N_FP      = 32'(TABLE_ENTRIES);
  localparam logic [REM_W-1:0]            N_REM     = REM_W'(TABLE_ENTRIES);
  localparam logic [nft_pkg::COUNT_W-1:0] N_CNT     = nft_pkg::COUNT_W'(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0]           LAST_ADDR = SLOT_W'(TABLE_ENTRIES - 1);

  // control state
  logic [nft_pkg::LEN_W-1:0]   len_cfg;
  logic [nft_pkg::HASH_W-1:0]  hash;
  logic [nft_pkg::LEN_W-1:0]   key_pos;
  logic [nft_pkg::COUNT_W-1:0] filled;
  logic [nft_pkg::STAT_W-1:0]  insert_cnt;
  logic [nft_pkg::STAT_W-1:0]  overwrite_cnt;
  logic [nft_pkg::STAT_W-1:0]  lookup_cnt;
  logic [nft_pkg::STAT_W-1:0]  hit_cnt;
  logic [nft_pkg::STAT_W-1:0]  miss_cnt;
  logic [SLOT_W-1:0]           sweep;
  logic                        out_valid;

  // payload
  nft_pkg::nft_mode_t          mode_q;
  logic [nft_pkg::TOKEN_W-1:0] tok_q;
  logic [nft_pkg::TOKEN_W-1:0] nxt_q;
  logic [nft_pkg::HASH_W-1:0]  p0;
  logic [nft_pkg::FP_W-1:0]    p1;
  logic [nft_pkg::FP_W-1:0]    p2;
  logic [nft_pkg::FP_W-1:0]    fp_q;
  logic [63:0]                 recip_prod;
  logic [nft_pkg::FP_W-1:0]    qn;
  logic [SLOT_W-1:0]           slot_q;
  logic                        f_found;
  logic                        f_miss;
  logic                        f_over;
  logic [nft_pkg::TOKEN_W-1:0] f_tok;
  nft_pkg::nft_slot_t          rd_data;

  nft_pkg::nft_slot_t          mem [TABLE_ENTRIES];

  // combinational
  logic [nft_pkg::LEN_W-1:0]   len_eff;
  logic [nft_pkg::LEN_W-1:0]   pos_inc;
  logic                        key_done;
  logic [32:0]                 lo_sum;
  logic [nft_pkg::FP_W-1:0]    hi_sum;
  logic [nft_pkg::HASH_W-1:0]  hash_sum;
  logic [nft_pkg::FP_W-1:0]    diff;
  logic [REM_W-1:0]            rem;
  logic [SLOT_W-1:0]           slot_calc;
  logic                        hit;
  logic                        mem_we;
  logic [SLOT_W-1:0]           mem_addr;
  nft_pkg::nft_slot_t          mem_wdata;

  // clamp the key length into its legal range
  always_comb begin
    if (len_cfg < nft_pkg::LEN_MIN) begin
      len_eff = nft_pkg::LEN_MIN;
    end else if (len_cfg > nft_pkg::LEN_MAX) begin
      len_eff = nft_pkg::LEN_MAX;
    end else begin
      len_eff = len_cfg;
    end
  end

  assign pos_inc  = key_pos + 5'd1;
  assign key_done = (pos_inc >= len_eff);

  // fold the partial products and the token into the next hash
  assign lo_sum   = {1'b0, p0[31:0]} + {2'b00, tok_q};
  assign hi_sum   = p0[63:32] + p1 + p2 + {31'd0, lo_sum[32]};
  assign hash_sum = {hi_sum, lo_sum[31:0]};

  // remainder estimate and its one-step correction
  assign diff      = fp_q - qn;
  assign rem       = diff[REM_W-1:0];
  assign slot_calc = (rem >= N_REM) ? SLOT_W'(rem - N_REM) : rem[SLOT_W-1:0];

  assign hit = rd_data.valid && (rd_data.fp == fp_q);

  // slot memory port: clearing sweep or the keyed slot
  assign mem_we    = cmd.clr_step || (cmd.update && (mode_q == nft_pkg::MODE_ADD));
  assign mem_addr  = cmd.clr_step ? sweep : slot_q;
  always_comb begin
    if (cmd.clr_step) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.valid = 1'b1;
      mem_wdata.fp    = fp_q;
      mem_wdata.token = nxt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // control state: config, key, counters, sweep, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg       <= nft_pkg::LEN_RESET;
      hash          <= '0;
      key_pos       <= '0;
      filled        <= '0;
      insert_cnt    <= '0;
      overwrite_cnt <= '0;
      lookup_cnt    <= '0;
      hit_cnt       <= '0;
      miss_cnt      <= '0;
      sweep         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_cfg <= cfg_wdata;
      end
      // advance the key; restart it on completion
      if (cmd.add) begin
        hash    <= key_done ? '0 : hash_sum;
        key_pos <= key_done ? '0 : pos_inc;
      end
      if (cmd.update) begin
        case (mode_q)
          nft_pkg::MODE_ADD: begin
            insert_cnt <= insert_cnt + 32'd1;
            if (rd_data.valid) begin
              overwrite_cnt <= overwrite_cnt + 32'd1;
            end else begin
              filled <= filled + 17'd1;
            end
          end
          nft_pkg::MODE_LOOKUP: begin
            lookup_cnt <= lookup_cnt + 32'd1;
            if (hit) begin
              hit_cnt <= hit_cnt + 32'd1;
            end else if (rd_data.valid) begin
              miss_cnt <= miss_cnt + 32'd1;
            end
          end
          default: filled <= filled;
        endcase
      end
      // walk the table once, emptying each slot
      if (cmd.clr_step) begin
        sweep  <= (sweep == LAST_ADDR) ? '0 : sweep + SLOT_W'(1);
        filled <= '0;
      end
      // hold the result until the response is taken
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= nft_pkg::nft_mode_t'(req_mode);
      tok_q   <= req_token;
      nxt_q   <= req_follow_token;
      f_found <= 1'b0;
      f_miss  <= 1'b0;
      f_over  <= 1'b0;
      f_tok   <= '0;
    end
    // three 32-bit partial products of hash * multiplier, mod 2^64
    if (cmd.mul) begin
      p0 <= 64'(hash[31:0]) * 64'(nft_pkg::MUL_LO);
      p1 <= 32'(hash[63:32] * nft_pkg::MUL_LO);
      p2 <= 32'(hash[31:0] * nft_pkg::MUL_HI);
    end
    if (cmd.add) begin
      fp_q <= hash_sum[63:32];
    end
    if (cmd.div1) begin
      recip_prod <= 64'(fp_q) * 64'(RECIP);
    end
    if (cmd.div2) begin
      qn <= 32'(recip_prod[63:32] * N_FP);
    end
    if (cmd.div3) begin
      slot_q <= slot_calc;
    end
    if (cmd.update) begin
      case (mode_q)
        nft_pkg::MODE_ADD: begin
          f_over <= rd_data.valid;
        end
        nft_pkg::MODE_LOOKUP: begin
          f_found <= hit;
          f_miss  <= rd_data.valid && !hit;
          f_tok   <= hit ? rd_data.token : '0;
        end
        default: f_over <= 1'b0;
      endcase
    end
    if (cmd.load_out) begin
      rsp.found            <= f_found;
      rsp.fingerprint_miss <= f_miss;
      rsp.overwrote        <= f_over;
      rsp.token_out        <= f_tok;
      rsp.used_count       <= filled;
      rsp.insert_total     <= insert_cnt;
      rsp.overwrite_total  <= overwrite_cnt;
      rsp.lookup_total     <= lookup_cnt;
      rsp.hit_total        <= hit_cnt;
      rsp.fp_miss_total    <= miss_cnt;
    end
  end

  assign rsp.valid = out_valid;

  // status to the controller
  assign sts.key_done   = key_done;
  assign sts.mode       = mode_q;
  assign sts.sweep_last = (sweep == LAST_ADDR);
  assign sts.out_free   = !out_valid || rsp.ready;

  `NFT_ASSERT(a_filled_bound, filled <= N_CNT)
  `NFT_ASSERT(a_key_pos_bound, key_pos < nft_pkg::LEN_MAX)
  `NFT_ASSERT_NEXT(a_slot_bound, cmd.div3, REM_W'(slot_q) < N_REM)
  `NFT_ASSERT_NEXT(a_clear_empties, cmd.clr_step, filled == '0)

endmodule

// ----- rtl/ngram_fingerprint_table.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table
// Direct-mapped n-gram predictor with fingerprinted slots and statistics.
// ----------------------------------------------------------------------------
// Key tokens arrive one per request and fold into a 64-bit running hash; the
// request that completes the key (ngram_length tokens, clamped to 1..16)
// picks add, lookup, clear or the unused mode, and only that request
// produces a response. A key token that does not complete the key passes
// through the 32x32 partial products of the hash multiply and then the
// 64-bit accumulate, and the next token is taken during the accumulate. A
// key completing with add or lookup goes through the hash, the reciprocal
// slot reduction, a registered table read, the read-modify-write, and the
// load of the response register before the next request is taken. A clear
// sweeps the slot memory one entry per cycle. After reset the same clearing
// pass runs before the first request is taken; configuration writes are
// taken at any time. Responses wait in an output register, so a stalled
// response holds back only the next completing key.
// ----------------------------------------------------------------------------
module ngram_fingerprint_table #(
  parameter int TABLE_ENTRIES = nft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [nft_pkg::LEN_W-1:0] cfg_wdata,
  nft_req_if.sink                   req,
  nft_rsp_if.source                 rsp
);

  nft_pkg::nft_cmd_t cmd;
  nft_pkg::nft_sts_t sts;
  logic              req_ready;

  assign req.ready = req_ready;

  // sequencer
  nft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash, slot reduction, table and result register
  nft_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_mode         (req.mode),
    .req_token        (req.token),
    .req_follow_token (req.follow_token),
    .cmd              (cmd),
    .sts              (sts),
    .rsp              (rsp)
  );

endmodule

// ----- tb/ngram_fingerprint_table_tb.sv -----
// ----------------------------------------------------------------------------
// N-gram fingerprint table testbench
// Streams key tokens through the request channel and checks every response
// against a behavioral copy of the table, hash and statistics. A short
// directed run covers the reset length, empty lookup, hit, overwrite, the
// unused mode and clear. Random phases then sweep the key length (values out
// of range included, some changed mid-key) and the idle/stall patterns.
// ----------------------------------------------------------------------------
module ngram_fingerprint_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nft_pkg::*;

  localparam int          ENTRIES     = 4096;
  localparam logic [63:0] HASH_FACTOR = 64'd6364136223846793005;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          MAX_REPORTS = 10;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 210;

  // key length written per phase and the idle/stall percentages that go with it
  localparam int unsigned PHASE_LEN   [NUM_PHASES] = '{0, 16, 3, 31, 2, 17, 1, 6};
  localparam int unsigned PHASE_SEND  [NUM_PHASES] = '{0, 81, 0, 31, 0, 81, 0, 31};
  localparam int unsigned PHASE_STALL [NUM_PHASES] = '{0, 0, 81, 31, 0, 0, 81, 31};

  typedef struct packed {
    nft_mode_t          mode;
    logic [TOKEN_W-1:0] token;
    logic [TOKEN_W-1:0] follow_token;
  } token_req_t;

  typedef struct packed {
    logic               found;
    logic               fp_miss;
    logic               overwrote;
    logic [TOKEN_W-1:0] token_out;
    logic [COUNT_W-1:0] used;
    logic [STAT_W-1:0]  inserts;
    logic [STAT_W-1:0]  overwrites;
    logic [STAT_W-1:0]  lookups;
    logic [STAT_W-1:0]  hits;
    logic [STAT_W-1:0]  fp_misses;
  } table_rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0]              len;
    logic [15:0][TOKEN_W-1:0]      toks;
  } ngram_key_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  nft_req_if req_ch ();
  nft_rsp_if rsp_ch ();

  ngram_fingerprint_table uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expected responses
  token_req_t  token_queue[$];
  table_rsp_t  pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned check_errors = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;

  // predicted table state
  bit                 tbl_valid [ENTRIES];
  logic [FP_W-1:0]    tbl_fp    [ENTRIES];
  logic [TOKEN_W-1:0] tbl_tok   [ENTRIES];
  logic [HASH_W-1:0]  key_hash;
  logic [LEN_W-1:0]   key_pos;
  logic [COUNT_W-1:0] filled;
  logic [STAT_W-1:0]  n_insert, n_over, n_lookup, n_hit, n_fpmiss;
  logic [LEN_W-1:0]   ngram_len;

  // generator's view of the table, used to steer keys onto filled slots
  bit              seen_valid [ENTRIES];
  logic [FP_W-1:0] seen_fp    [ENTRIES];
  ngram_key_t      added_keys[$];
  int unsigned     gen_pos = 0;

  function automatic int unsigned clamp_len(logic [LEN_W-1:0] v);
    if (v < LEN_MIN) return 1;
    if (v > LEN_MAX) return 16;
    return {27'd0, v};
  endfunction

  function automatic logic [HASH_W-1:0] fold_token(logic [HASH_W-1:0] h,
                                                   logic [TOKEN_W-1:0] t);
    return h * HASH_FACTOR + {33'd0, t};
  endfunction

  function automatic logic [FP_W-1:0] key_fp(ngram_key_t k);
    logic [HASH_W-1:0] h;
    h = '0;
    for (int i = 0; i < k.len; i++) h = fold_token(h, k.toks[i]);
    return h[63:32];
  endfunction

  function automatic logic [TOKEN_W-1:0] rand_token();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return r[TOKEN_W-1:0];
    endcase
  endfunction

  function automatic ngram_key_t random_key(int unsigned n);
    ngram_key_t k;
    k = '0;
    k.len = n[LEN_W-1:0];
    for (int i = 0; i < n; i++) k.toks[i] = rand_token();
    return k;
  endfunction

  // search for a key that lands on a filled slot under another fingerprint
  function automatic ngram_key_t clashing_key(int unsigned n);
    ngram_key_t      k;
    logic [FP_W-1:0] fp;
    k = random_key(n);
    for (int i = 0; i < 300; i++) begin
      k = random_key(n);
      fp = key_fp(k);
      if (seen_valid[fp % ENTRIES] && seen_fp[fp % ENTRIES] != fp) return k;
    end
    return k;
  endfunction

  task automatic clear_table_model();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_fp[i] = '0;
      tbl_tok[i] = '0;
    end
    filled = '0;
  endtask

  // fold one accepted request into the key; on key completion apply the op
  task automatic predict_table_op(token_req_t r);
    table_rsp_t      e;
    logic [FP_W-1:0] fp;
    int unsigned     s;
    key_hash = fold_token(key_hash, r.token);
    key_pos = key_pos + 5'd1;
    if (key_pos < clamp_len(ngram_len)) return;
    fp = key_hash[63:32];
    s = fp % ENTRIES;
    key_hash = '0;
    key_pos = '0;
    e = '0;
    case (r.mode)
      MODE_ADD: begin
        n_insert = n_insert + 32'd1;
        if (tbl_valid[s]) begin
          n_over = n_over + 32'd1;
          e.overwrote = 1'b1;
        end else begin
          filled = filled + 17'd1;
        end
        tbl_valid[s] = 1'b1;
        tbl_fp[s] = fp;
        tbl_tok[s] = r.follow_token;
      end
      MODE_LOOKUP: begin
        n_lookup = n_lookup + 32'd1;
        if (tbl_valid[s]) begin
          if (tbl_fp[s] == fp) begin
            n_hit = n_hit + 32'd1;
            e.found = 1'b1;
            e.token_out = tbl_tok[s];
          end else begin
            n_fpmiss = n_fpmiss + 32'd1;
            e.fp_miss = 1'b1;
          end
        end
      end
      MODE_CLEAR: clear_table_model();
      default: ;
    endcase
    e.used = filled;
    e.inserts = n_insert;
    e.overwrites = n_over;
    e.lookups = n_lookup;
    e.hits = n_hit;
    e.fp_misses = n_fpmiss;
    pending_results.push_back(e);
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      check_errors++;
      if (check_errors <= MAX_REPORTS)
        $display("response %0d: %s expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
    end
  endtask

  // queue the tokens of one key; mode and follow token matter only on the last
  task automatic queue_key(ngram_key_t k, nft_mode_t m, logic [TOKEN_W-1:0] nt);
    token_req_t item;
    for (int i = 0; i < k.len; i++) begin
      item.token = k.toks[i];
      if (i == k.len - 1) begin
        item.mode = m;
        item.follow_token = nt;
      end else begin
        item.mode = nft_mode_t'(2'($urandom_range(3)));
        item.follow_token = rand_token();
      end
      token_queue.push_back(item);
    end
  endtask

  // hold until every request is taken, every response is back, and the
  // block has settled
  task automatic wait_idle();
    while (token_queue.size() != 0 || req_ch.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    ngram_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed add/lookup sequences, with replays and slot clashes
  task automatic queue_phase(int unsigned n_items);
    int unsigned     eff, queued, clears, need, r, extra;
    ngram_key_t      k;
    nft_mode_t       m;
    bit              tracked;
    logic [FP_W-1:0] fp;
    eff = clamp_len(ngram_len);
    queued = 0;
    clears = 0;
    added_keys.delete();
    while (queued < n_items) begin
      r = $urandom_range(99);
      tracked = (gen_pos == 0);
      need = (eff > gen_pos) ? eff - gen_pos : 1;
      k = random_key(need);
      if (r < 30) begin
        m = MODE_ADD;
      end else if (r < 38) begin
        m = MODE_ADD;
        if (tracked) k = clashing_key(eff);
      end else if (r < 43) begin
        m = MODE_ADD;
        if (tracked && added_keys.size() != 0)
          k = added_keys[$urandom_range(added_keys.size() - 1)];
      end else if (r < 65) begin
        m = MODE_LOOKUP;
        if (tracked && added_keys.size() != 0)
          k = added_keys[$urandom_range(added_keys.size() - 1)];
      end else if (r < 77) begin
        m = MODE_LOOKUP;
        if (tracked) k = clashing_key(eff);
      end else if (r < 94) begin
        m = MODE_LOOKUP;
      end else if (r < 98) begin
        m = MODE_NONE;
      end else if (clears == 0) begin
        m = MODE_CLEAR;
        clears++;
      end else begin
        m = MODE_LOOKUP;
      end
      queue_key(k, m, rand_token());
      // track what the table will hold
      if (m == MODE_CLEAR) begin
        for (int i = 0; i < ENTRIES; i++) seen_valid[i] = 1'b0;
        added_keys.delete();
      end else if (m == MODE_ADD && tracked) begin
        fp = key_fp(k);
        seen_valid[fp % ENTRIES] = 1'b1;
        seen_fp[fp % ENTRIES] = fp;
        added_keys.push_back(k);
      end
      queued += k.len;
      gen_pos = 0;
    end
    // leave part of a key open so the next length change lands mid-key
    if (eff > 1 && $urandom_range(1) == 1) begin
      extra = $urandom_range((eff - 1 > 3) ? 3 : eff - 1, 1);
      queue_key(random_key(extra), nft_mode_t'(2'($urandom_range(3))), rand_token());
      gen_pos = extra;
    end
  endtask

  // request driver; predict on every accepted request
  always @(posedge clk) begin
    token_req_t taken, nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken.mode = nft_mode_t'(req_ch.mode);
        taken.token = req_ch.token;
        taken.follow_token = req_ch.follow_token;
        predict_table_op(taken);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (token_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = token_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode <= nxt.mode;
          req_ch.token <= nxt.token;
          req_ch.follow_token <= nxt.follow_token;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor, random back-pressure and watchdog
  always @(posedge clk) begin
    table_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          check_errors++;
          if (check_errors <= MAX_REPORTS)
            $display("response %0d: unexpected, found=%0b token_out=0x%0h",
                     results_seen, rsp_ch.found, rsp_ch.token_out);
        end else begin
          want = pending_results.pop_front();
          compare_field("found", 64'(want.found), 64'(rsp_ch.found));
          compare_field("fingerprint_miss", 64'(want.fp_miss),
                        64'(rsp_ch.fingerprint_miss));
          compare_field("overwrote", 64'(want.overwrote), 64'(rsp_ch.overwrote));
          compare_field("token_out", 64'(want.token_out), 64'(rsp_ch.token_out));
          compare_field("used_count", 64'(want.used), 64'(rsp_ch.used_count));
          compare_field("insert_total", 64'(want.inserts), 64'(rsp_ch.insert_total));
          compare_field("overwrite_total", 64'(want.overwrites),
                        64'(rsp_ch.overwrite_total));
          compare_field("lookup_total", 64'(want.lookups), 64'(rsp_ch.lookup_total));
          compare_field("hit_total", 64'(want.hits), 64'(rsp_ch.hit_total));
          compare_field("fp_miss_total", 64'(want.fp_misses),
                        64'(rsp_ch.fp_miss_total));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    ngram_key_t k;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.token = '0;
    req_ch.follow_token = '0;
    rsp_ch.ready = 1'b0;
    clear_table_model();
    key_hash = '0;
    key_pos = '0;
    n_insert = '0;
    n_over = '0;
    n_lookup = '0;
    n_hit = '0;
    n_fpmiss = '0;
    ngram_len = 5'd4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset length of four, empty lookup, add, hit, overwrite,
    // unused mode, clear, then a key left open across a length change
    k = '0;
    k.len = 5'd4;
    queue_key(k, MODE_LOOKUP, '1);
    k.toks = '1;
    queue_key(k, MODE_ADD, '1);
    queue_key(k, MODE_LOOKUP, '0);
    queue_key(k, MODE_ADD, '0);
    queue_key(random_key(4), MODE_NONE, '1);
    queue_key(random_key(4), MODE_CLEAR, '1);
    queue_key(random_key(2), MODE_ADD, rand_token());
    gen_pos = 2;

    // random phases over lengths and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_length(PHASE_LEN[p][LEN_W-1:0]);
      send_idle_pct = PHASE_SEND[p];
      stall_pct = PHASE_STALL[p];
      queue_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (check_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
